// ===== hdl/avr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants for the axis-angle vector rotator
// Item structs for both channels, fixed-point constants and the CORDIC
// arctangent table in 2^32-per-turn units.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int TRIG_STEPS_DEF = 16;
  localparam int ATAN_COUNT     = 24;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               axis_zero;
    logic               clipped;
  } out_item_t;

  // arctangent of 2^-i, one turn = 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/axis_angle_vector_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate: rotate a Q16.16 vector about an arbitrary axis
// Normalizes the axis, takes sine/cosine of the half angle, builds the
// quaternion rotation matrix and applies it, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one request: a vector in
//   signed Q16.16, an axis direction of any nonzero scale and a binary angle
//   (65536 = one turn). Output channel out_valid/out_stall/out_data returns
//   the rotated vector, an axis_zero flag (vector passed unchanged) and a
//   clipped flag (some component saturated).
//   A request is taken at each edge with valid high and stall low.
//   Throughput: one request per cycle while the output is not stalled.
//   The depth is the same for any TRIG_STEPS and is set by the
//   square root of the axis length (2 root bits per stage, 16 stages) and
//   the three parallel restoring dividers for the unit axis (2 quotient bits
//   per stage, 16 stages); the CORDIC (one iteration per stage) runs beside
//   them and is padded with a delay line.
//   All stages advance together. When out_stall holds a valid result the
//   whole pipeline freezes and in_stall rises in the same cycle; empty slots
//   are filled while the output is free, so a waiting result never blocks
//   intake by itself. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears every stage valid bit; the first
//   request may follow right after reset is released.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate #(
  parameter int TRIG_STEPS = avr_pkg::TRIG_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire avr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output avr_pkg::out_item_t      out_data
);

  localparam int TS     = (TRIG_STEPS > avr_pkg::ATAN_COUNT) ? avr_pkg::ATAN_COUNT
                                                               : TRIG_STEPS;
  localparam int SQ_ST  = 16;   // square-root stages
  localparam int DIV_ST = 16;   // divider stages
  localparam int FRONT  = 3;    // input, squares, sum
  localparam int SIDE_N = FRONT + SQ_ST + DIV_ST;
  localparam int DLY    = SIDE_N - 1 - TS;   // pad CORDIC to divider end
  localparam int PO_N   = 4;

  // Per-request side data that rides along the pipeline
  typedef struct packed {
    logic             vld;
    logic             zero;
    logic [2:0][31:0] vec;
    logic [2:0][15:0] axis;
    logic [15:0]      turn;
  } side_t;

  logic en;

  // --------------------------------------------------------------------------
  // Global advance: freeze everything only while a result is held
  // --------------------------------------------------------------------------
  logic out_vld_r;
  avr_pkg::out_item_t out_r;

  assign en        = !out_vld_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Side line, stage 1 to SIDE_N
  // --------------------------------------------------------------------------
  side_t sd_in;
  side_t sd_r [1:SIDE_N];

  always_comb begin
    sd_in.vld  = in_valid;
    sd_in.zero = (in_data.axis_x == 16'sd0) && (in_data.axis_y == 16'sd0) &&
                 (in_data.axis_z == 16'sd0);
    sd_in.vec  = {in_data.vec_z, in_data.vec_y, in_data.vec_x};
    sd_in.axis = {in_data.axis_z, in_data.axis_y, in_data.axis_x};
    sd_in.turn = in_data.turn_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= SIDE_N; k++) sd_r[k].vld <= 1'b0;
    end else if (en) begin
      sd_r[1] <= sd_in;
      for (int k = 2; k <= SIDE_N; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Squared axis length: squares at stage 2, sum at stage 3
  // --------------------------------------------------------------------------
  logic [2:0][30:0] sqa_r;
  logic [31:0]      n2_r;
  logic signed [31:0] sqp [3];

  always_comb begin
    for (int l = 0; l < 3; l++) sqp[l] = $signed(sd_r[1].axis[l]) * $signed(sd_r[1].axis[l]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) sqa_r[l] <= sqp[l][30:0];
      n2_r <= 32'(sqa_r[0]) + 32'(sqa_r[1]) + 32'(sqa_r[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Square root of n2 * 2^32, two root bits per stage
  // --------------------------------------------------------------------------
  logic [33:0] sq_rem_nxt  [1:SQ_ST];
  logic [31:0] sq_root_nxt [1:SQ_ST];
  logic [33:0] sq_rem_r    [1:SQ_ST];
  logic [31:0] sq_root_r   [1:SQ_ST];
  logic [31:0] sq_n2_r     [1:SQ_ST];

  for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [31:0] n2_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n2_i   = n2_r;
    end else begin : g_next
      assign rem_i  = sq_rem_r[k];
      assign root_i = sq_root_r[k];
      assign n2_i   = sq_n2_r[k];
    end

    always_comb begin
      logic [35:0] acc;
      logic [35:0] trial;
      logic [31:0] rt;
      logic [63:0] vv;
      logic [1:0]  pr;
      acc = {2'b00, rem_i};
      rt  = root_i;
      vv  = {n2_i, 32'd0};
      for (int j = 0; j < 2; j++) begin
        pr    = 2'(vv >> (62 - 4 * k - 2 * j));
        acc   = {acc[33:0], pr};
        trial = {2'b00, rt, 2'b01};
        if (acc >= trial) begin
          acc = acc - trial;
          rt  = {rt[30:0], 1'b1};
        end else begin
          rt  = {rt[30:0], 1'b0};
        end
      end
      sq_rem_nxt[k+1]  = acc[33:0];
      sq_root_nxt[k+1] = rt;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= sq_rem_nxt[k+1];
        sq_root_r[k+1] <= sq_root_nxt[k+1];
        sq_n2_r[k+1]   <= n2_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Unit axis: (|a| * 2^46) / len, three restoring dividers, 2 bits a stage
  // --------------------------------------------------------------------------
  logic [2:0][32:0] dv_rem_nxt [1:DIV_ST];
  logic [2:0][31:0] dv_q_nxt   [1:DIV_ST];
  logic [2:0][32:0] dv_rem_r   [1:DIV_ST];
  logic [2:0][31:0] dv_q_r     [1:DIV_ST];
  logic [31:0]      dv_len_r   [1:DIV_ST];

  for (genvar k = 0; k < DIV_ST; k++) begin : g_dv
    logic [2:0][32:0] rem_i;
    logic [2:0][31:0] q_i;
    logic [31:0]      len_i;

    if (k == 0) begin : g_first
      logic [2:0][15:0] mag;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          mag[l]   = sd_r[FRONT+SQ_ST].axis[l][15] ? (~sd_r[FRONT+SQ_ST].axis[l] + 16'd1)
                                                   : sd_r[FRONT+SQ_ST].axis[l];
          rem_i[l] = {3'b000, mag[l], 14'd0};
          q_i[l]   = '0;
        end
      end
      assign len_i = sq_root_r[SQ_ST];
    end else begin : g_next
      assign rem_i = dv_rem_r[k];
      assign q_i   = dv_q_r[k];
      assign len_i = dv_len_r[k];
    end

    always_comb begin
      logic [32:0] t;
      logic [31:0] q;
      for (int l = 0; l < 3; l++) begin
        t = rem_i[l];
        q = q_i[l];
        for (int j = 0; j < 2; j++) begin
          t = {t[31:0], 1'b0};
          if (t >= {1'b0, len_i}) begin
            t = t - {1'b0, len_i};
            q = {q[30:0], 1'b1};
          end else begin
            q = {q[30:0], 1'b0};
          end
        end
        dv_rem_nxt[k+1][l] = t;
        dv_q_nxt[k+1][l]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= dv_rem_nxt[k+1];
        dv_q_r[k+1]   <= dv_q_nxt[k+1];
        dv_len_r[k+1] <= len_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Half-angle CORDIC, one iteration per stage, beside the root/divider
  // --------------------------------------------------------------------------
  logic signed [33:0] cx_nxt [1:TS];
  logic signed [33:0] cy_nxt [1:TS];
  logic signed [33:0] ch_nxt [1:TS];
  logic signed [33:0] cx_r   [1:TS];
  logic signed [33:0] cy_r   [1:TS];
  logic signed [33:0] ch_r   [1:TS];
  logic               cn_r   [1:TS];

  for (genvar i = 0; i < TS; i++) begin : g_cor
    logic signed [33:0] x_i;
    logic signed [33:0] y_i;
    logic signed [33:0] h_i;
    logic               n_i;
    logic signed [33:0] at;

    if (i == 0) begin : g_first
      logic signed [33:0] h0;
      // fold angles at or past a quarter turn, negate sine and cosine later
      assign h0  = $signed({3'b000, sd_r[1].turn, 15'd0});
      assign n_i = sd_r[1].turn[15];
      assign h_i = n_i ? (h0 - 34'sh0_8000_0000) : h0;
      assign x_i = avr_pkg::CORDIC_GAIN;
      assign y_i = '0;
    end else begin : g_next
      assign x_i = cx_r[i];
      assign y_i = cy_r[i];
      assign h_i = ch_r[i];
      assign n_i = cn_r[i];
    end

    assign at = $signed({2'b00, avr_pkg::atan_turn(5'(i))});

    always_comb begin
      if (!h_i[33]) begin
        cx_nxt[i+1] = x_i - (y_i >>> i);
        cy_nxt[i+1] = y_i + (x_i >>> i);
        ch_nxt[i+1] = h_i - at;
      end else begin
        cx_nxt[i+1] = x_i + (y_i >>> i);
        cy_nxt[i+1] = y_i - (x_i >>> i);
        ch_nxt[i+1] = h_i + at;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1] <= cx_nxt[i+1];
        cy_r[i+1] <= cy_nxt[i+1];
        ch_r[i+1] <= ch_nxt[i+1];
        cn_r[i+1] <= n_i;
      end
    end
  end

  function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_4000_0000)       r = avr_pkg::ONE_Q30;
    else if (v < -34'sh0_4000_0000) r = -avr_pkg::ONE_Q30;
    else                            r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] sin_c;
  logic signed [31:0] cos_c;
  logic signed [31:0] sc_s_r [1:DLY];
  logic signed [31:0] sc_c_r [1:DLY];

  always_comb begin
    cos_c = clamp34(cx_r[TS]);
    sin_c = clamp34(cy_r[TS]);
    if (cn_r[TS]) begin
      cos_c = -cos_c;
      sin_c = -sin_c;
    end
  end

  // hold sine/cosine until the dividers finish
  always_ff @(posedge clk) begin
    if (en) begin
      sc_s_r[1] <= sin_c;
      sc_c_r[1] <= cos_c;
      for (int k = 2; k <= DLY; k++) begin
        sc_s_r[k] <= sc_s_r[k-1];
        sc_c_r[k] <= sc_c_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Back end: quaternion, products, matrix, vector products, output
  // --------------------------------------------------------------------------
  side_t po_r [1:PO_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= PO_N; k++) po_r[k].vld <= 1'b0;
    end else if (en) begin
      po_r[1] <= sd_r[SIDE_N];
      for (int k = 2; k <= PO_N; k++) po_r[k] <= po_r[k-1];
    end
  end

  // quaternion vector part: unit axis times half-angle sine
  logic signed [31:0] qv_r [3];
  logic signed [31:0] w_r;
  logic signed [63:0] qp [3];

  always_comb begin
    logic [31:0]        qc;
    logic signed [31:0] u;
    for (int l = 0; l < 3; l++) begin
      qc    = (dv_q_r[DIV_ST][l] > 32'h4000_0000) ? 32'h4000_0000 : dv_q_r[DIV_ST][l];
      u     = sd_r[SIDE_N].axis[l][15] ? -$signed(qc) : $signed(qc);
      qp[l] = u * sc_s_r[DLY];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) qv_r[l] <= qp[l][61:30];
      w_r <= sc_c_r[DLY];
    end
  end

  // nine quaternion products
  logic signed [31:0] xx_r, xy_r, xz_r, yy_r, yz_r, zz_r, wx_r, wy_r, wz_r;

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= mulq(qv_r[0], qv_r[0]);
      xy_r <= mulq(qv_r[0], qv_r[1]);
      xz_r <= mulq(qv_r[0], qv_r[2]);
      yy_r <= mulq(qv_r[1], qv_r[1]);
      yz_r <= mulq(qv_r[1], qv_r[2]);
      zz_r <= mulq(qv_r[2], qv_r[2]);
      wx_r <= mulq(w_r, qv_r[0]);
      wy_r <= mulq(w_r, qv_r[1]);
      wz_r <= mulq(w_r, qv_r[2]);
    end
  end

  // rotation matrix entries
  function automatic logic signed [34:0] twice(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic               sub);
    logic signed [34:0] s;
    s = sub ? (35'(a) - 35'(b)) : (35'(a) + 35'(b));
    return s <<< 1;
  endfunction

  function automatic logic signed [31:0] clamp35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_4000_0000)       r = avr_pkg::ONE_Q30;
    else if (v < -35'sh0_4000_0000) r = -avr_pkg::ONE_Q30;
    else                            r = v[31:0];
    return r;
  endfunction

  logic signed [34:0] one35;
  logic signed [31:0] m_r [9];

  assign one35 = 35'(avr_pkg::ONE_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= clamp35(one35 - twice(yy_r, zz_r, 1'b0));
      m_r[1] <= clamp35(twice(xy_r, wz_r, 1'b1));
      m_r[2] <= clamp35(twice(xz_r, wy_r, 1'b0));
      m_r[3] <= clamp35(twice(xy_r, wz_r, 1'b0));
      m_r[4] <= clamp35(one35 - twice(xx_r, zz_r, 1'b0));
      m_r[5] <= clamp35(twice(yz_r, wx_r, 1'b1));
      m_r[6] <= clamp35(twice(xz_r, wy_r, 1'b1));
      m_r[7] <= clamp35(twice(yz_r, wx_r, 1'b0));
      m_r[8] <= clamp35(one35 - twice(xx_r, yy_r, 1'b0));
    end
  end

  // vector times matrix, one multiplier per entry
  logic signed [63:0] vm_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          vm_r[3*r+c] <= $signed(po_r[3].vec[c]) * m_r[3*r+c];
        end
      end
    end
  end

  // row sums, round half up, saturate
  logic signed [31:0] rot_c [3];
  logic               clip_c;

  always_comb begin
    logic signed [65:0] acc;
    logic signed [35:0] rs;
    clip_c = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc = 66'(vm_r[3*r]) + 66'(vm_r[3*r+1]) + 66'(vm_r[3*r+2]) + 66'sd536870912;
      rs  = acc[65:30];
      if (rs > 36'sh0_7FFF_FFFF) begin
        rot_c[r] = 32'sh7FFF_FFFF;
        clip_c   = 1'b1;
      end else if (rs < -36'sh0_8000_0000) begin
        rot_c[r] = 32'sh8000_0000;
        clip_c   = 1'b1;
      end else begin
        rot_c[r] = rs[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= po_r[PO_N].vld;
    end
  end

  // zero axis: pass the vector through untouched
  always_ff @(posedge clk) begin
    if (en) begin
      if (po_r[PO_N].zero) begin
        out_r.rot_x   <= $signed(po_r[PO_N].vec[0]);
        out_r.rot_y   <= $signed(po_r[PO_N].vec[1]);
        out_r.rot_z   <= $signed(po_r[PO_N].vec[2]);
        out_r.clipped <= 1'b0;
      end else begin
        out_r.rot_x   <= rot_c[0];
        out_r.rot_y   <= rot_c[1];
        out_r.rot_z   <= rot_c[2];
        out_r.clipped <= clip_c;
      end
      out_r.axis_zero <= po_r[PO_N].zero;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/avr_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// avr_check: port-level checks for the axis-angle vector rotator
// Watches the request channels and result flags; bound to the top level.
// ----------------------------------------------------------------------------
module avr_check (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire avr_pkg::out_item_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  // intake stops only behind a held result
  a_in_stall: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a pass-through never reports clipping
  a_zero_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_zero |-> !out_data.clipped)
    else $error("zero axis flagged as clipped");

  // clipping shows as a full-scale component
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      out_data.rot_x == 32'sh7FFF_FFFF || out_data.rot_x == 32'sh8000_0000 ||
      out_data.rot_y == 32'sh7FFF_FFFF || out_data.rot_y == 32'sh8000_0000 ||
      out_data.rot_z == 32'sh7FFF_FFFF || out_data.rot_z == 32'sh8000_0000)
    else $error("clipped without a saturated component");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind axis_angle_vector_rotate avr_check u_avr_check (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the axis-angle vector rotator
// Drives rotation requests, predicts each rotated vector with a bit-exact
// model of the fixed-point pipeline, and compares results in order under
// random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY = 39;
  localparam int STEPS   = avr_pkg::TRIG_STEPS_DEF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  avr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  avr_pkg::out_item_t out_data;

  // expected rotated vectors, oldest first
  avr_pkg::out_item_t rot_expected[$];
  int        fail_count = 0;
  // receiver hold-off request, in cycles
  int        hold_cycles = 0;
  // 0: random stalls, 1: never stall
  bit        out_free = 1'b0;
  bit        in_steady = 1'b0;

  axis_angle_vector_rotate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction helpers
  // ---------------------------------------------------------------------------
  localparam longint ONE = 64'sd1073741824;

  // arithmetic shift right is already floor for signed values
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp1(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint mq(longint a, longint b);
    return fshr(a * b, 30);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_axis(longint a, logic [63:0] len);
    logic [63:0] mag;
    longint q;
    mag = (a < 0) ? -a : a;
    q = longint'((mag << 46) / len);
    if (q > ONE) q = ONE;
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint row_out(longint v0, longint v1, longint v2,
                                     longint m0, longint m1, longint m2,
                                     ref bit clip);
    longint r;
    r = fshr(v0 * m0 + v1 * m1 + v2 * m2 + (64'sd1 <<< 29), 30);
    if (r > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return r;
  endfunction

  function automatic avr_pkg::out_item_t predict_rotation(avr_pkg::in_item_t req);
    avr_pkg::out_item_t res;
    longint v[3], a[3], m[9];
    longint h, x, y, nx, s, c, qx, qy, qz, w;
    longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
    logic [63:0] n2, len;
    bit neg, clip;
    v[0] = req.vec_x; v[1] = req.vec_y; v[2] = req.vec_z;
    a[0] = req.axis_x; a[1] = req.axis_y; a[2] = req.axis_z;
    clip = 1'b0;
    n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    if (n2 == 0) begin
      res.rot_x = req.vec_x;
      res.rot_y = req.vec_y;
      res.rot_z = req.vec_z;
      res.axis_zero = 1'b1;
      res.clipped = 1'b0;
      return res;
    end
    len = root64(n2 << 32);
    // half angle; fold the upper half turn and negate afterwards
    h = longint'({48'd0, req.turn_angle}) << 15;
    neg = 1'b0;
    if (h >= (64'sd1 <<< 30)) begin
      h = h - (64'sd1 <<< 31);
      neg = 1'b1;
    end
    x = avr_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < STEPS && i < avr_pkg::ATAN_COUNT; i++) begin
      if (h >= 0) begin
        nx = x - fshr(y, i);
        y = y + fshr(x, i);
        h = h - longint'(avr_pkg::atan_turn(i[4:0]));
      end else begin
        nx = x + fshr(y, i);
        y = y - fshr(x, i);
        h = h + longint'(avr_pkg::atan_turn(i[4:0]));
      end
      x = nx;
    end
    x = clamp1(x);
    y = clamp1(y);
    c = neg ? -x : x;
    s = neg ? -y : y;
    qx = mq(unit_axis(a[0], len), s);
    qy = mq(unit_axis(a[1], len), s);
    qz = mq(unit_axis(a[2], len), s);
    w = c;
    xx = mq(qx, qx); xy = mq(qx, qy); xz = mq(qx, qz);
    yy = mq(qy, qy); yz = mq(qy, qz); zz = mq(qz, qz);
    wx = mq(w, qx); wy = mq(w, qy); wz = mq(w, qz);
    m[0] = ONE - 2 * (yy + zz);
    m[1] = 2 * (xy - wz);
    m[2] = 2 * (xz + wy);
    m[3] = 2 * (xy + wz);
    m[4] = ONE - 2 * (xx + zz);
    m[5] = 2 * (yz - wx);
    m[6] = 2 * (xz - wy);
    m[7] = 2 * (yz + wx);
    m[8] = ONE - 2 * (xx + yy);
    for (int k = 0; k < 9; k++) m[k] = clamp1(m[k]);
    res.rot_x = row_out(v[0], v[1], v[2], m[0], m[1], m[2], clip);
    res.rot_y = row_out(v[0], v[1], v[2], m[3], m[4], m[5], clip);
    res.rot_z = row_out(v[0], v[1], v[2], m[6], m[7], m[8], clip);
    res.axis_zero = 1'b0;
    res.clipped = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and hold it until accepted; valid stays high afterwards
  // so that a request without a gap follows right away
  task automatic send_rotation(avr_pkg::in_item_t req);
    int idle;
    idle = in_steady ? 0 : gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rot_expected.push_back(predict_rotation(req));
  endtask

  function automatic logic signed [31:0] rand_vec();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic avr_pkg::in_item_t make_req(logic signed [31:0] vx,
                                                 logic signed [31:0] vy,
                                                 logic signed [31:0] vz,
                                                 logic signed [15:0] ax,
                                                 logic signed [15:0] ay,
                                                 logic signed [15:0] az,
                                                 logic [15:0] ang);
    avr_pkg::in_item_t r;
    r.vec_x = vx; r.vec_y = vy; r.vec_z = vz;
    r.axis_x = ax; r.axis_y = ay; r.axis_z = az;
    r.turn_angle = ang;
    return r;
  endfunction

  // drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rot_expected.size() != 0) @(posedge clk);
  endtask

  // zero axis, quarter/half turns, full-scale values and saturation
  task automatic test_directed();
    send_rotation(make_req(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 16'h4000));
    send_rotation(make_req(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 16'hFFFF));
    send_rotation(make_req(32'sh0001_0000, 0, 0, 0, 0, 1, 16'h0000));
    send_rotation(make_req(32'sh0001_0000, 0, 0, 0, 0, 1, 16'h4000));
    send_rotation(make_req(32'sh0001_0000, 0, 0, 0, 0, 1, 16'h8000));
    send_rotation(make_req(32'sh0001_0000, 0, 0, 0, 0, 1, 16'hC000));
    send_rotation(make_req(32'sh0001_0000, 0, 0, 0, 0, 1, 16'hFFFF));
    send_rotation(make_req(0, 32'sh0001_0000, 0, 16'sh7FFF, 0, 0, 16'h2000));
    send_rotation(make_req(0, 0, 32'sh0001_0000, 0, 16'sh8000, 0, 16'h6000));
    send_rotation(make_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           0, 0, 1, 16'h2000));
    send_rotation(make_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           1, 1, 1, 16'h1555));
    send_rotation(make_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                           16'sh8000, 16'sh8000, 16'sh8000, 16'h7FFF));
    send_rotation(make_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h8001));
    send_rotation(make_req(32'shFFFF_FFFF, 1, 32'shFFFF_0000, -1, 16'sh7FFF, 1, 16'h3FFF));
    send_rotation(make_req(32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F,
                           3, -4, 12, 16'hA5A5));
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++)
      send_rotation(make_req(rand_vec(), rand_vec(), rand_vec(),
                             rand_axis(), rand_axis(), rand_axis(), 16'($urandom)));
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_cycles = 120;
    in_steady = 1'b1;
    test_random(80);
    in_steady = 1'b0;
    wait_drained();
  endtask

  // sender pauses on an empty pipeline, then streams with a free receiver
  task automatic test_streaming();
    wait_drained();
    out_free = 1'b1;
    in_steady = 1'b1;
    test_random(100);
    in_steady = 1'b0;
    out_free = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall drive
  // ---------------------------------------------------------------------------
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else if (out_free) begin
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run = stall_run - 1;
      end else begin
        stall_run = gap_len();
        out_stall <= (stall_run > 0);
        if (stall_run > 0) stall_run = stall_run - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    avr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rot_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = rot_expected.pop_front();
        if (out_data.rot_x !== want.rot_x) begin
          $display("%0t: rot_x expected %h actual %h", $time, want.rot_x, out_data.rot_x);
          fail_count++;
        end
        if (out_data.rot_y !== want.rot_y) begin
          $display("%0t: rot_y expected %h actual %h", $time, want.rot_y, out_data.rot_y);
          fail_count++;
        end
        if (out_data.rot_z !== want.rot_z) begin
          $display("%0t: rot_z expected %h actual %h", $time, want.rot_z, out_data.rot_z);
          fail_count++;
        end
        if (out_data.axis_zero !== want.axis_zero) begin
          $display("%0t: axis_zero expected %b actual %b", $time, want.axis_zero,
                   out_data.axis_zero);
          fail_count++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                   out_data.clipped);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run each test, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_streaming();
    test_random(420);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && rot_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
